/* rtl/bcs_pkg.sv */
// Shared types and constants for the binned count, sum, minimum and maximum unit.
package bcs_pkg;

    localparam int BIN_W    = 12;
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 48;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] min;
        logic [SAMPLE_W-1:0] max;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        count: '0,
        sum:   '0,
        min:   SAMPLE_MAX,
        max:   SAMPLE_MIN
    };

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic clear;
        logic rd_in;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_status;

endpackage

/* rtl/bcs_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module bcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bcs_ctrl.sv */
// Controller: clearing pass, beat acceptance and result hand-off sequencing.
module bcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  bcs_pkg::t_status i_status,
    output bcs_pkg::t_cmd    o_cmd
);
    import bcs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.rd_in  = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_UPDATE: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/bcs_dpath.sv */
// Datapath: statistics memory, clearing counter, update arithmetic and result register.
module bcs_dpath #(
    parameter int NUM_BINS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bcs_pkg::t_cmd                       i_cmd,
    output bcs_pkg::t_status                    o_status,
    input  logic [bcs_pkg::BIN_W-1:0]           i_bin_index,
    input  logic signed [bcs_pkg::SAMPLE_W-1:0] i_sample,
    output logic [bcs_pkg::BIN_W-1:0]           o_bin_out,
    output logic [bcs_pkg::COUNT_W-1:0]         o_bin_count,
    output logic signed [bcs_pkg::SUM_W-1:0]    o_bin_sum,
    output logic signed [bcs_pkg::SAMPLE_W-1:0] o_bin_min,
    output logic signed [bcs_pkg::SAMPLE_W-1:0] o_bin_max,
    output logic                                o_saturated
);
    import bcs_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);

    logic [ADDR_W-1:0]   r_clr_addr;
    logic [BIN_W-1:0]    r_bin;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_in_range;

    logic [BIN_W-1:0]    r_out_bin;
    logic [COUNT_W-1:0]  r_out_count;
    logic [SUM_W-1:0]    r_out_sum;
    logic [SAMPLE_W-1:0] r_out_min;
    logic [SAMPLE_W-1:0] r_out_max;
    logic                r_out_sat;

    logic [ADDR_W-1:0]   bin_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    t_entry              cur;
    t_entry              upd;
    logic                count_sat;
    logic [SUM_W:0]      sum_wide;
    logic                sum_ovf;

    assign bin_addr = ADDR_W'(r_bin);

    assign ram_we    = i_cmd.clear || (i_cmd.commit && r_in_range);
    assign ram_waddr = i_cmd.clear ? r_clr_addr : bin_addr;
    assign ram_wdata = i_cmd.clear ? ENTRY_RESET : upd;
    assign ram_raddr = i_cmd.rd_in ? ADDR_W'(i_bin_index) : bin_addr;

    bcs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_BINS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_status.clear_last = (r_clr_addr == ADDR_W'(NUM_BINS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bin      <= i_bin_index;
            r_sample   <= i_sample;
            r_in_range <= (32'(i_bin_index) < 32'(NUM_BINS));
        end
    end

    always_comb begin
        cur       = t_entry'(ram_rdata);
        count_sat = &cur.count;
        sum_wide  = {cur.sum[SUM_W-1], cur.sum}
                  + {{(SUM_W + 1 - SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
        sum_ovf   = sum_wide[SUM_W] != sum_wide[SUM_W-1];

        upd.count = count_sat ? cur.count : cur.count + 1'b1;
        if (sum_ovf) begin
            upd.sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            upd.sum = sum_wide[SUM_W-1:0];
        end
        upd.min = ($signed(r_sample) < $signed(cur.min)) ? r_sample : cur.min;
        upd.max = ($signed(r_sample) > $signed(cur.max)) ? r_sample : cur.max;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_bin <= r_bin;
            if (r_in_range) begin
                r_out_count <= upd.count;
                r_out_sum   <= upd.sum;
                r_out_min   <= upd.min;
                r_out_max   <= upd.max;
                r_out_sat   <= count_sat || sum_ovf;
            end else begin
                r_out_count <= ENTRY_RESET.count;
                r_out_sum   <= ENTRY_RESET.sum;
                r_out_min   <= ENTRY_RESET.min;
                r_out_max   <= ENTRY_RESET.max;
                r_out_sat   <= 1'b0;
            end
        end
    end

    assign o_bin_out   = r_out_bin;
    assign o_bin_count = r_out_count;
    assign o_bin_sum   = r_out_sum;
    assign o_bin_min   = r_out_min;
    assign o_bin_max   = r_out_max;
    assign o_saturated = r_out_sat;

endmodule

/* rtl/binned_count_sum_min_max_unit.sv */
// Top level of the binned count, sum, minimum and maximum unit.
//
// Each input beat carries a bin index and a signed sample. The unit updates
// that bin's count, sum, minimum and maximum and returns one output beat with
// the updated statistics of the bin. Indices at or above NUM_BINS update
// nothing and return the cleared statistics. Count and sum saturate, and the
// saturated flag marks the beat that clipped.
// A beat is taken when valid is high and stall is low on its channel.
// After an input beat is taken, its bin is read from the statistics memory
// and the result is then loaded into the output register once that register
// is free or drains. One beat is processed at a time, so no new input beat is
// taken until the current one is written back: the single statistics memory
// is read in the cycle of acceptance and written back as the result is loaded.
// After reset the memory is swept once, one bin per cycle, over all NUM_BINS
// bins; input stall stays high during that pass.
// When the receiver stalls, the result waits in the output register and the
// update of the next beat is held until the register is free.
module binned_count_sum_min_max_unit #(
    parameter int NUM_BINS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bcs_pkg::BIN_W-1:0]           i_bin_index,
    input  logic signed [bcs_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bcs_pkg::BIN_W-1:0]           o_bin_out,
    output logic [bcs_pkg::COUNT_W-1:0]         o_bin_count,
    output logic signed [bcs_pkg::SUM_W-1:0]    o_bin_sum,
    output logic signed [bcs_pkg::SAMPLE_W-1:0] o_bin_min,
    output logic signed [bcs_pkg::SAMPLE_W-1:0] o_bin_max,
    output logic                                o_saturated
);
    import bcs_pkg::*;

    t_cmd    cmd;
    t_status status;

    bcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bcs_dpath #(
        .NUM_BINS(NUM_BINS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_bin_index(i_bin_index),
        .i_sample   (i_sample),
        .o_bin_out  (o_bin_out),
        .o_bin_count(o_bin_count),
        .o_bin_sum  (o_bin_sum),
        .o_bin_min  (o_bin_min),
        .o_bin_max  (o_bin_max),
        .o_saturated(o_saturated)
    );

endmodule

/* rtl/bcs_checker.sv */
// Port-level checks for the binned statistics unit and their binding to it.
module bcs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [bcs_pkg::BIN_W-1:0]           o_bin_out,
    input logic [bcs_pkg::COUNT_W-1:0]         o_bin_count,
    input logic signed [bcs_pkg::SUM_W-1:0]    o_bin_sum,
    input logic signed [bcs_pkg::SAMPLE_W-1:0] o_bin_min,
    input logic signed [bcs_pkg::SAMPLE_W-1:0] o_bin_max,
    input logic                                o_saturated
);
    import bcs_pkg::*;

    // A beat in flight blocks the input for at least the following cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a beat is still being processed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_bin_out) && $stable(o_bin_count)
            && $stable(o_bin_sum) && $stable(o_bin_min) && $stable(o_bin_max))
        else $error("stalled output beat changed");

    // A bin that holds samples has a minimum no larger than its maximum.
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_bin_count != '0) |-> (o_bin_min <= o_bin_max))
        else $error("minimum above maximum in a filled bin");

    // An empty result only comes from an index at or above NUM_BINS and carries cleared values.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_bin_count == '0) |->
            (o_bin_sum == '0) && !o_saturated
            && (o_bin_min == SAMPLE_MAX) && (o_bin_max == SAMPLE_MIN))
        else $error("empty result with non-cleared statistics");

endmodule

bind binned_count_sum_min_max_unit bcs_checker u_bcs_checker (.*);
